[design/cmh_pkg.sv]
// Shared types, constants and the bucket hash for the count-min sketch counter unit.
// Depends on nothing; every other design file but cmh_ram imports it.
package cmh_pkg;

  localparam int ROWS        = 4;
  localparam int BUCKET_BITS = 10;
  localparam int BUCKETS     = 1 << BUCKET_BITS;
  localparam int KEY_BYTES   = 8;

  localparam int KEY_W     = 64;
  localparam int KEY_LEN_W = 4;
  localparam int CNT_W     = 8;
  localparam int SEED_W    = 32;
  localparam int SEED_REGS = 4;
  localparam int CFG_IDX_W = 2;
  localparam int TALLY_W   = 31;
  localparam int KIND_W    = 2;

  // h*33 is h + (h << 5)
  localparam int HASH_SHIFT = 5;

  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

  localparam logic [SEED_REGS-1:0][SEED_W-1:0] SEED_RESET = {
    32'd4, 32'd3, 32'd2, 32'd1
  };

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [KEY_W-1:0]     key_bytes;
    logic [KEY_LEN_W-1:0] key_length;
    logic [CNT_W-1:0]     add_amount;
  } in_t;

  typedef struct packed {
    logic [CNT_W-1:0]   estimate;
    logic               overflow_cleared;
    logic [TALLY_W-1:0] insert_total;
    logic               total_valid;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic update;
    logic clear_step;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic go_clear;
    logic clr_last;
  } sts_t;

  // Only the low BUCKET_BITS of the hash reach the bucket, so carry just those.
  function automatic logic [BUCKET_BITS-1:0] bucket_of(
    input logic [SEED_W-1:0]    seed,
    input logic [KEY_W-1:0]     key,
    input logic [KEY_LEN_W-1:0] len
  );
    logic [BUCKET_BITS-1:0] h;
    logic [BUCKET_BITS-1:0] b;
    h = seed[BUCKET_BITS-1:0];
    for (int k = 0; k < KEY_BYTES; k++) begin
      b = {{(BUCKET_BITS-8){key[8*k+7]}}, key[8*k +: 8]};
      if (KEY_LEN_W'(k) < len) begin
        h = h + (h << HASH_SHIFT) + b;
      end
    end
    return h;
  endfunction

endpackage

[design/cmh_ram.sv]
// Generic single-clock RAM: one write port, one read port with registered read data.
// Standalone; no package needed.
module cmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/cmh_ctrl.sv]
// Controller for the count-min sketch unit: idle, update and clearing-pass states.
// Depends on cmh_pkg for the command and status structs.
module cmh_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  output cmh_pkg::cmd_t cmd_o,
  input  cmh_pkg::sts_t sts_i
);
  import cmh_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_UPDATE = 3'b010,
    ST_CLEAR  = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_d = sts_i.go_clear ? ST_CLEAR : ST_IDLE;
      end
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Reset lands in the clearing pass so the store starts zeroed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o            = (state_q != ST_IDLE);
  assign cmd_o.load        = (state_q == ST_IDLE) && start_i;
  assign cmd_o.update      = (state_q == ST_UPDATE);
  assign cmd_o.clear_step  = (state_q == ST_CLEAR);

`ifndef SYNTHESIS
  a_accept_then_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> cmd_o.update)
    else $error("accepted beat not followed by update");

  a_update_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |=> !cmd_o.update)
    else $error("update held longer than one cycle");
`endif

endmodule

[design/cmh_datapath.sv]
// Datapath of the count-min sketch unit: seeds, bucket hash, counter banks,
// insert tally and result register. Depends on cmh_pkg and cmh_ram.
module cmh_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cmh_pkg::in_t                   cmd_data_i,
  input  logic                           cfg_we_i,
  input  logic [cmh_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cmh_pkg::SEED_W-1:0]     cfg_wdata_i,
  input  cmh_pkg::cmd_t                  cmd_i,
  output cmh_pkg::sts_t                  sts_o,
  output cmh_pkg::out_t                  result_o,
  output logic                           result_valid_o
);
  import cmh_pkg::*;

  logic [SEED_REGS-1:0][SEED_W-1:0]  seeds_q;
  logic [ROWS-1:0][BUCKET_BITS-1:0]  bucket_d, bucket_q;
  logic [KIND_W-1:0]                 kind_q;
  logic [CNT_W-1:0]                  amount_q;
  logic [BUCKET_BITS-1:0]            clr_addr_q;
  logic [ROWS-1:0][CNT_W-1:0]        rdata;
  logic [ROWS-1:0][CNT_W:0]          sum;
  logic [ROWS-1:0]                   row_ovf;
  logic                              ovf;
  logic                              bank_we;
  logic [CNT_W-1:0]                  row_min;
  logic [TALLY_W-1:0]                tally_q, tally_d;
  logic                              cleared_q, cleared_d;
  out_t                              result_q, result_d;
  logic                              result_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeds_q <= SEED_RESET;
    end else if (cfg_we_i) begin
      seeds_q[cfg_index_i] <= cfg_wdata_i;
    end
  end

  // Hash straight from the ports so the bank read issues on the accept edge.
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      bucket_d[r] = bucket_of(seeds_q[r], cmd_data_i.key_bytes, cmd_data_i.key_length);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bucket_q <= bucket_d;
      kind_q   <= cmd_data_i.kind;
      amount_q <= cmd_data_i.add_amount;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clear_step) begin
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  assign bank_we = cmd_i.clear_step || (cmd_i.update && (kind_q == KIND_INSERT));

  for (genvar r = 0; r < ROWS; r++) begin : g_row
    assign sum[r]     = {1'b0, rdata[r]} + {1'b0, amount_q};
    assign row_ovf[r] = sum[r][CNT_W];

    cmh_ram #(
      .WIDTH (CNT_W),
      .DEPTH (BUCKETS)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we),
      .waddr_i (cmd_i.clear_step ? clr_addr_q : bucket_q[r]),
      .wdata_i (cmd_i.clear_step ? '0 : sum[r][CNT_W-1:0]),
      .re_i    (cmd_i.load),
      .raddr_i (bucket_d[r]),
      .rdata_o (rdata[r])
    );
  end

  assign ovf = |row_ovf;

  always_comb begin
    row_min = CNT_MAX;
    for (int r = 0; r < ROWS; r++) begin
      if (rdata[r] < row_min) row_min = rdata[r];
    end
  end

  always_comb begin
    tally_d   = tally_q;
    cleared_d = cleared_q;
    result_d  = '0;
    if (cmd_i.update) begin
      case (kind_q)
        KIND_INSERT: begin
          if (tally_q != TALLY_MAX) tally_d = tally_q + 1'b1;
          if (ovf) begin
            tally_d   = '0;
            cleared_d = 1'b1;
            result_d.overflow_cleared = 1'b1;
          end
        end
        KIND_QUERY: begin
          result_d.estimate = (row_min == CNT_MAX) ? '0 : row_min;
        end
        KIND_CLEAR: begin
          tally_d   = '0;
          cleared_d = 1'b1;
        end
        default: ;
      endcase
    end
    result_d.insert_total = tally_d;
    result_d.total_valid  = !cleared_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q        <= '0;
      cleared_q      <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      tally_q        <= tally_d;
      cleared_q      <= cleared_d;
      result_valid_q <= cmd_i.update;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      result_q <= result_d;
    end
  end

  assign sts_o.go_clear = (kind_q == KIND_CLEAR) || ((kind_q == KIND_INSERT) && ovf);
  assign sts_o.clr_last = &clr_addr_q;
  assign result_o       = result_q;
  assign result_valid_o = result_valid_q;

`ifndef SYNTHESIS
  a_result_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_q |-> $past(cmd_i.update))
    else $error("result beat without an update");

  a_ovf_clears_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_q && result_q.overflow_cleared) |->
      (result_q.insert_total == '0 && !result_q.total_valid))
    else $error("overflow beat with total not cleared");
`endif

endmodule

[design/count_min_sketch_counter_unit.sv]
// Top level of the count-min sketch counter unit: controller plus datapath.
// Depends on cmh_pkg, cmh_ctrl, cmh_datapath (and cmh_ram below it).
//
// Usage:
//   Command channel: drive cmd_i and raise start_i; the beat is taken at a
//   rising edge where start_i is high and busy_o is low. kind selects insert,
//   query or clear-all; kind 3 does nothing but still returns a result.
//   Result channel: every command gives one result beat on result_o, marked
//   by result_valid_o for one cycle. The receiver cannot stall it.
//   Configuration: cfg_we_i writes cfg_wdata_i into the row seed chosen by
//   cfg_index_i at that edge; write only while busy_o is low.
// Timing:
//   The bank read is issued on the accept edge, the read-modify-write runs in
//   the following cycle, and the result beat shows in the cycle after that.
//   busy_o drops with the result beat, so a new command can be taken during it;
//   the limit is the registered read plus the write-back in each row bank.
//   A clear command, or an insert that overflows a counter, returns its beat
//   and then holds busy_o for a pass over all BUCKETS addresses zeroing all banks.
//   Reset restores the default seeds and runs the same zeroing pass.
module count_min_sketch_counter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  cmh_pkg::in_t                  cmd_i,
  output cmh_pkg::out_t                 result_o,
  output logic                          result_valid_o,
  input  logic                          cfg_we_i,
  input  logic [cmh_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [cmh_pkg::SEED_W-1:0]    cfg_wdata_i
);
  import cmh_pkg::*;

  cmd_t ctl_cmd;
  sts_t dp_sts;

  cmh_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (ctl_cmd),
    .sts_i   (dp_sts)
  );

  cmh_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_data_i     (cmd_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (ctl_cmd),
    .sts_o          (dp_sts),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule
